/* rtl/core/bdq_pkg.sv */
// Shared types and codes for the bounded deque queue.
// No dependencies; imported by the queue top level.
package bdq_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_PUSH   = 2'd1;
  localparam mode_t MODE_POP    = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 5;
  localparam int COUNT_W = 5;

endpackage

/* rtl/core/bdq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bounded_deque_queue.sv */
// Bounded double-ended word queue kept in a circular buffer RAM.
// An accepted item gives its result, marked by done, in the next cycle.
// Throughput: one item per cycle; busy stays low, since the single RAM read of a pop
// lands in the result cycle and is forwarded into the cached head word.
// The receiver cannot stall. Synchronous reset empties the queue and clears item_limit;
// the slot RAM itself is not cleared.
module bounded_deque_queue #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdq_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  bdq_pkg::mode_t                  mode,
  input  logic [bdq_pkg::WORD_W-1:0]      item_in,
  output logic                            done,
  output bdq_pkg::status_t                status,
  output logic [bdq_pkg::WORD_W-1:0]      item_out,
  output logic [bdq_pkg::COUNT_W-1:0]     item_count,
  output logic                            head_valid,
  output logic [bdq_pkg::WORD_W-1:0]      head_item
);

  import bdq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [LIMIT_W-1:0] item_limit;
  logic [AW-1:0]      head_idx, head_idx_next;
  logic [AW-1:0]      tail_idx, tail_idx_next;
  logic [CW-1:0]      count, count_next;
  logic [WORD_W-1:0]  head_word, head_word_next;
  logic               pop_pend, pop_pend_next;
  logic               accept;
  logic               full;
  logic [WORD_W-1:0]  eff_head;
  logic [AW-1:0]      head_inc, head_dec, tail_inc;
  logic [CMPW-1:0]    count_cmp, limit_cmp;
  logic [CW+COUNT_W-1:0] count_ext;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  status_t            res_status;
  logic [WORD_W-1:0]  res_out;

  bdq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign accept    = start && !busy;

  assign head_inc = (head_idx == LAST_IDX) ? '0 : head_idx + AW'(1);
  assign head_dec = (head_idx == '0) ? LAST_IDX : head_idx - AW'(1);
  assign tail_inc = (tail_idx == LAST_IDX) ? '0 : tail_idx + AW'(1);

  assign count_cmp = CMPW'(count);
  assign limit_cmp = CMPW'(item_limit);
  assign full = (count >= CW'(DEPTH)) ||
                ((item_limit != '0) && (count_cmp >= limit_cmp));

  // The RAM output carries the new head word in the cycle after a pop.
  assign eff_head = pop_pend ? ram_rdata : head_word;

  always_comb begin
    head_idx_next  = head_idx;
    tail_idx_next  = tail_idx;
    count_next     = count;
    head_word_next = eff_head;
    pop_pend_next  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = tail_idx;
    ram_wdata      = item_in;
    ram_re         = 1'b0;
    ram_raddr      = head_inc;
    res_status     = ST_OK;
    res_out        = '0;
    if (accept) begin
      case (mode)
        MODE_APPEND: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = tail_idx;
            tail_idx_next = tail_inc;
            count_next    = count + CW'(1);
            if (count == '0) begin
              head_word_next = item_in;
            end
          end
        end
        MODE_PUSH: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = head_dec;
            head_idx_next  = head_dec;
            head_word_next = item_in;
            count_next     = count + CW'(1);
          end
        end
        MODE_POP: begin
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_out       = eff_head;
            ram_re        = 1'b1;
            head_idx_next = head_inc;
            count_next    = count - CW'(1);
            pop_pend_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_limit <= '0;
      head_idx   <= '0;
      tail_idx   <= '0;
      count      <= '0;
      pop_pend   <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        item_limit <= cfg_data;
      end
      head_idx <= head_idx_next;
      tail_idx <= tail_idx_next;
      count    <= count_next;
      pop_pend <= pop_pend_next;
      done     <= accept;
    end
  end

  always_ff @(posedge clk) begin
    head_word <= head_word_next;
    if (accept) begin
      status   <= res_status;
      item_out <= res_out;
    end
  end

  assign count_ext  = {{COUNT_W{1'b0}}, count};
  assign item_count = count_ext[COUNT_W-1:0];
  assign head_valid = (count != '0);
  assign head_item  = head_valid ? eff_head : '0;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result strobe missing after an accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("held count exceeds capacity");

  a_refused_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_EMPTY)) |-> $stable(count))
    else $error("refused operation changed the count");

endmodule
